FILE: design/bff_pkg.sv
// ----------------------------------------------------------------------------
// bff_pkg: shared types and constants of the banked framebuffer flush
// Field widths, register and command codes, and the command/status structs
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bff_pkg;

  // field and state widths
  localparam int unsigned CRD_W    = 13;  // signed rectangle coordinate
  localparam int unsigned DIM_W    = 12;  // screen dimension, row length
  localparam int unsigned STR_W    = 13;  // stride in bytes
  localparam int unsigned AP_W     = 23;  // aperture size
  localparam int unsigned POS_W    = 22;  // byte offsets
  localparam int unsigned PAGE_W   = 18;  // aperture page
  localparam int unsigned OFF_W    = 25;  // linear start offset
  localparam int unsigned CFG_W    = 23;  // widest register
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_CNT_W = $clog2(OFF_W);

  // aperture size limits
  localparam logic [AP_W-1:0] AP_MIN = AP_W'(16);
  localparam logic [AP_W-1:0] AP_MAX = AP_W'(4194304);

  // register reset values
  localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);
  localparam logic [AP_W-1:0]  RST_AP     = AP_W'(65536);

  // item kinds
  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_ROW   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_APERTURE_SIZE = 2'd2,
    CFG_FLUSH_ENABLE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_PAGE_SELECT = 2'd0,
    OP_COPY        = 2'd1,
    OP_ROWS_DONE   = 2'd2,
    OP_NOTHING     = 2'd3
  } op_e;

  // which result the datapath loads into the output register
  typedef enum logic [2:0] {
    EM_PAGE        = 3'd0,
    EM_COPY_FULL   = 3'd1,
    EM_COPY_FIRST  = 3'd2,
    EM_COPY_SECOND = 3'd3,
    EM_DONE        = 3'd4,
    EM_EMPTY       = 3'd5
  } emit_sel_e;

  typedef struct packed {
    logic      latch_in;    // capture the accepted item
    logic      prep;        // clip rectangle, register start values
    logic      div_start;   // start the page divider
    logic      load_begin;  // commit page, offsets and row counts
    logic      eval;        // evaluate the current row
    logic      commit_row;  // advance to the next row
    logic      emit;        // load the output register
    emit_sel_e emit_sel;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic kind;         // kind of the item in hand
    logic empty;        // nothing to flush for this rectangle
    logic div_done;     // divider result ready
    logic rows_zero;    // no rows left
    logic fits;         // row plus stride stays inside the page
    logic room_le_len;  // page end falls within the row
    logic room_nz;      // first part of a split is not empty
    logic second_nz;    // second part of a split is not empty
    logic out_free;     // output register can take a result
  } sts_t;

endpackage

FILE: design/bff_if.sv
// ----------------------------------------------------------------------------
// bff_if: item channels of the banked framebuffer flush
// Input channel carries rectangle and row-step items, output channel carries
// page select and copy commands. Valid/ready handshake on both.
// ----------------------------------------------------------------------------
interface bff_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [bff_pkg::CRD_W-1:0]    x_min;
  logic signed [bff_pkg::CRD_W-1:0]    y_min;
  logic signed [bff_pkg::CRD_W-1:0]    x_max;
  logic signed [bff_pkg::CRD_W-1:0]    y_max;

  modport source (output valid, kind, x_min, y_min, x_max, y_max, input ready);
  modport sink   (input valid, kind, x_min, y_min, x_max, y_max, output ready);
endinterface

interface bff_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [bff_pkg::PAGE_W-1:0]    page;
  logic [bff_pkg::POS_W-1:0]     dest_offset;
  logic [bff_pkg::POS_W-1:0]     src_offset;
  logic [bff_pkg::DIM_W-1:0]     length;
  logic                          last;

  modport source (output valid, op, page, dest_offset, src_offset, length, last,
                  input ready);
  modport sink   (input valid, op, page, dest_offset, src_offset, length, last,
                  output ready);
endinterface

FILE: design/bff_div.sv
// ----------------------------------------------------------------------------
// bff_div: iterative page divider
// Restoring division of the start offset by the aperture size, one quotient
// bit per cycle; done is registered and pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module bff_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bff_pkg::OFF_W-1:0]     dividend_i,
  input  logic [bff_pkg::AP_W-1:0]      divisor_i,
  output logic                          done_o,
  output logic [bff_pkg::OFF_W-1:0]     quo_o,
  output logic [bff_pkg::POS_W-1:0]     rem_o
);

  logic [bff_pkg::OFF_W-1:0]     quo_q, quo_d;
  logic [bff_pkg::POS_W-1:0]     rem_q, rem_d;
  logic [bff_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [bff_pkg::AP_W-1:0]      trial;
  logic [bff_pkg::AP_W-1:0]      diff;
  logic                          ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[bff_pkg::OFF_W-1]};
  assign ge    = (trial >= divisor_i);
  assign diff  = trial - divisor_i;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = bff_pkg::DIV_CNT_W'(bff_pkg::OFF_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[bff_pkg::OFF_W-2:0], ge};
      rem_d = ge ? diff[bff_pkg::POS_W-1:0] : trial[bff_pkg::POS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: design/bff_dp.sv
// ----------------------------------------------------------------------------
// bff_dp: datapath of the banked framebuffer flush
// Configuration registers, rectangle clipping and start offset, flush state,
// row evaluation and the output register.
// ----------------------------------------------------------------------------
module bff_dp #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [bff_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bff_pkg::CFG_W-1:0]         cfg_data_i,
  // input item payload
  input  logic                              in_kind_i,
  input  logic signed [bff_pkg::CRD_W-1:0]  in_x_min_i,
  input  logic signed [bff_pkg::CRD_W-1:0]  in_y_min_i,
  input  logic signed [bff_pkg::CRD_W-1:0]  in_x_max_i,
  input  logic signed [bff_pkg::CRD_W-1:0]  in_y_max_i,
  // controller link
  input  bff_pkg::cmd_t                     cmd_i,
  output bff_pkg::sts_t                     sts_o,
  // result item
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        out_op_o,
  output logic [bff_pkg::PAGE_W-1:0]        out_page_o,
  output logic [bff_pkg::POS_W-1:0]         out_dest_o,
  output logic [bff_pkg::POS_W-1:0]         out_src_o,
  output logic [bff_pkg::DIM_W-1:0]         out_len_o,
  output logic                              out_last_o
);

  localparam int unsigned LIM_W = bff_pkg::DIM_W + 2;
  localparam logic [LIM_W-1:0] MaxW = LIM_W'(MAX_WIDTH);
  localparam logic [LIM_W-1:0] MaxH = LIM_W'(MAX_HEIGHT);

  // configuration registers
  logic [bff_pkg::DIM_W-1:0]  sw_q, sh_q;
  logic [bff_pkg::AP_W-1:0]   ap_q;
  logic                       en_q;

  // effective screen and aperture
  logic [bff_pkg::DIM_W-1:0]  eff_w, eff_h;
  logic [bff_pkg::STR_W-1:0]  stride_sum, stride;
  logic [bff_pkg::AP_W-1:0]   eff_ap;

  // latched item
  logic                             kind_q;
  logic signed [bff_pkg::CRD_W-1:0] x0_q, y0_q, x1_q, y1_q;

  // clipping
  logic signed [bff_pkg::CRD_W-1:0] w_s, h_s, x0c, y0c, x1c, y1c, dx, dy;
  logic                             empty;
  logic [bff_pkg::OFF_W-1:0]        prod, off;

  // start values kept over the division
  logic [bff_pkg::DIM_W-1:0]  rl_q, rn_q;
  logic [bff_pkg::POS_W-1:0]  src_start_q;

  // divider
  logic                       div_done;
  logic [bff_pkg::OFF_W-1:0]  div_quo;
  logic [bff_pkg::POS_W-1:0]  div_rem;

  // flush state
  logic [bff_pkg::PAGE_W-1:0] cur_page_q;
  logic [bff_pkg::POS_W-1:0]  dest_pos_q, src_pos_q;
  logic [bff_pkg::DIM_W-1:0]  row_len_q, rows_left_q;

  // row evaluation
  logic [bff_pkg::AP_W:0]     dest_plus;
  logic [bff_pkg::AP_W:0]     dest_wrap;
  logic                       fits;
  logic [bff_pkg::AP_W-1:0]   room;
  logic                       room_le_len;
  logic                       fits_q, room_le_q, room_nz_q, second_nz_q;
  logic [bff_pkg::DIM_W-1:0]  room_q;

  // output register
  logic                       out_valid_q;
  bff_pkg::op_e               out_op_q;
  logic [bff_pkg::PAGE_W-1:0] out_page_q;
  logic [bff_pkg::POS_W-1:0]  out_dest_q, out_src_q;
  logic [bff_pkg::DIM_W-1:0]  out_len_q;
  logic                       out_last_q;
  logic                       out_free;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= bff_pkg::RST_WIDTH;
      sh_q <= bff_pkg::RST_HEIGHT;
      ap_q <= bff_pkg::RST_AP;
      en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (bff_pkg::cfg_idx_e'(cfg_idx_i))
        bff_pkg::CFG_SCREEN_WIDTH:  sw_q <= cfg_data_i[bff_pkg::DIM_W-1:0];
        bff_pkg::CFG_SCREEN_HEIGHT: sh_q <= cfg_data_i[bff_pkg::DIM_W-1:0];
        bff_pkg::CFG_APERTURE_SIZE: ap_q <= cfg_data_i;
        bff_pkg::CFG_FLUSH_ENABLE:  en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // saturate screen size, round stride up to a multiple of four bytes, clamp aperture
  assign eff_w = ({2'b00, sw_q} > MaxW) ? MaxW[bff_pkg::DIM_W-1:0] : sw_q;
  assign eff_h = ({2'b00, sh_q} > MaxH) ? MaxH[bff_pkg::DIM_W-1:0] : sh_q;
  assign stride_sum = {1'b0, eff_w} + bff_pkg::STR_W'(3);
  assign stride     = {stride_sum[bff_pkg::STR_W-1:2], 2'b00};
  assign eff_ap = (ap_q < bff_pkg::AP_MIN) ? bff_pkg::AP_MIN :
                  (ap_q > bff_pkg::AP_MAX) ? bff_pkg::AP_MAX : ap_q;

  // capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= in_kind_i;
      x0_q   <= in_x_min_i;
      y0_q   <= in_y_min_i;
      x1_q   <= in_x_max_i;
      y1_q   <= in_y_max_i;
    end
  end

  // clip the rectangle to the screen and form the start offset
  assign w_s   = signed'({1'b0, eff_w});
  assign h_s   = signed'({1'b0, eff_h});
  assign x0c   = x0_q[bff_pkg::CRD_W-1] ? '0 : x0_q;
  assign y0c   = y0_q[bff_pkg::CRD_W-1] ? '0 : y0_q;
  assign x1c   = (x1_q > w_s) ? w_s : x1_q;
  assign y1c   = (y1_q > h_s) ? h_s : y1_q;
  assign dx    = x1c - x0c;
  assign dy    = y1c - y0c;
  assign empty = !en_q || (x0c >= x1c) || (y0c >= y1c);
  assign prod  = bff_pkg::OFF_W'(y0c[bff_pkg::DIM_W-1:0]) * bff_pkg::OFF_W'(stride);
  assign off   = prod + bff_pkg::OFF_W'(x0c[bff_pkg::DIM_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      rl_q        <= dx[bff_pkg::DIM_W-1:0];
      rn_q        <= dy[bff_pkg::DIM_W-1:0];
      src_start_q <= off[bff_pkg::POS_W-1:0];
    end
  end

  bff_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (off),
    .divisor_i  (eff_ap),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // evaluate where the current row ends against the page end
  assign dest_plus   = (bff_pkg::AP_W+1)'(dest_pos_q) + (bff_pkg::AP_W+1)'(stride);
  assign dest_wrap   = dest_plus - (bff_pkg::AP_W+1)'(eff_ap);
  assign fits        = (dest_plus < (bff_pkg::AP_W+1)'(eff_ap));
  assign room        = (bff_pkg::AP_W'(dest_pos_q) < eff_ap) ?
                       (eff_ap - bff_pkg::AP_W'(dest_pos_q)) : '0;
  assign room_le_len = (room <= bff_pkg::AP_W'(row_len_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      fits_q      <= fits;
      room_le_q   <= room_le_len;
      room_nz_q   <= (room != '0);
      second_nz_q <= (room[bff_pkg::DIM_W-1:0] != row_len_q);
      room_q      <= room[bff_pkg::DIM_W-1:0];
    end
  end

  // flush state: load at rectangle start, advance per row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_page_q  <= '0;
      dest_pos_q  <= '0;
      src_pos_q   <= '0;
      row_len_q   <= '0;
      rows_left_q <= '0;
    end else begin
      if (cmd_i.prep && empty) begin
        rows_left_q <= '0;
      end
      if (cmd_i.load_begin) begin
        cur_page_q  <= div_quo[bff_pkg::PAGE_W-1:0];
        dest_pos_q  <= div_rem;
        src_pos_q   <= src_start_q;
        row_len_q   <= rl_q;
        rows_left_q <= rn_q;
      end
      if (cmd_i.eval && (rows_left_q != '0) && !fits) begin
        cur_page_q <= cur_page_q + 1'b1;
      end
      if (cmd_i.commit_row) begin
        dest_pos_q  <= fits_q ? dest_plus[bff_pkg::POS_W-1:0]
                              : dest_wrap[bff_pkg::POS_W-1:0];
        src_pos_q   <= src_pos_q + bff_pkg::POS_W'(stride);
        rows_left_q <= rows_left_q - 1'b1;
      end
    end
  end

  // output register: load a result when free, drop it once taken
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_page_q <= '0;
      out_dest_q <= '0;
      out_src_q  <= '0;
      out_len_q  <= '0;
      out_last_q <= cmd_i.emit_last;
      case (cmd_i.emit_sel)
        bff_pkg::EM_PAGE: begin
          out_op_q   <= bff_pkg::OP_PAGE_SELECT;
          out_page_q <= cur_page_q;
        end
        bff_pkg::EM_COPY_FULL: begin
          out_op_q   <= bff_pkg::OP_COPY;
          out_dest_q <= dest_pos_q;
          out_src_q  <= src_pos_q;
          out_len_q  <= row_len_q;
        end
        bff_pkg::EM_COPY_FIRST: begin
          out_op_q   <= bff_pkg::OP_COPY;
          out_dest_q <= dest_pos_q;
          out_src_q  <= src_pos_q;
          out_len_q  <= room_q;
        end
        bff_pkg::EM_COPY_SECOND: begin
          out_op_q  <= bff_pkg::OP_COPY;
          out_src_q <= src_pos_q + bff_pkg::POS_W'(room_q);
          out_len_q <= row_len_q - room_q;
        end
        bff_pkg::EM_DONE: begin
          out_op_q <= bff_pkg::OP_ROWS_DONE;
        end
        default: begin
          out_op_q <= bff_pkg::OP_NOTHING;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_op_o    = out_op_q;
  assign out_page_o  = out_page_q;
  assign out_dest_o  = out_dest_q;
  assign out_src_o   = out_src_q;
  assign out_len_o   = out_len_q;
  assign out_last_o  = out_last_q;

  // status towards the controller
  assign sts_o.kind        = kind_q;
  assign sts_o.empty       = empty;
  assign sts_o.div_done    = div_done;
  assign sts_o.rows_zero   = (rows_left_q == '0);
  assign sts_o.fits        = fits_q;
  assign sts_o.room_le_len = room_le_q;
  assign sts_o.room_nz     = room_nz_q;
  assign sts_o.second_nz   = second_nz_q;
  assign sts_o.out_free    = out_free;

endmodule

FILE: design/bff_ctrl.sv
// ----------------------------------------------------------------------------
// bff_ctrl: controller of the banked framebuffer flush
// Sequences an item through clipping, division or row evaluation and issues
// up to three results into the output register.
// ----------------------------------------------------------------------------
module bff_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_kind_i,
  output logic          in_ready_o,
  input  bff_pkg::sts_t sts_i,
  output bff_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PREP  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_EVAL  = 8'b0000_1000,
    S_COPY1 = 8'b0001_0000,
    S_PAGE  = 8'b0010_0000,
    S_COPY2 = 8'b0100_0000,
    S_END   = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  bff_pkg::cmd_t cmd;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.latch_in = 1'b1;
          state_d = (in_kind_i == bff_pkg::KIND_BEGIN) ? S_PREP : S_EVAL;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts_i.empty) begin
          state_d = S_END;
        end else begin
          cmd.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd.load_begin = 1'b1;
          state_d = S_PAGE;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_d = sts_i.rows_zero ? S_END : S_COPY1;
      end
      S_COPY1: begin
        if (sts_i.fits) begin
          if (sts_i.out_free) begin
            cmd.emit       = 1'b1;
            cmd.emit_sel   = bff_pkg::EM_COPY_FULL;
            cmd.emit_last  = 1'b1;
            cmd.commit_row = 1'b1;
            state_d = S_IDLE;
          end
        end else if (sts_i.room_le_len && !sts_i.room_nz) begin
          state_d = S_PAGE;
        end else if (sts_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = sts_i.room_le_len ? bff_pkg::EM_COPY_FIRST
                                           : bff_pkg::EM_COPY_FULL;
          state_d = S_PAGE;
        end
      end
      S_PAGE: begin
        if (sts_i.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = bff_pkg::EM_PAGE;
          if (sts_i.kind == bff_pkg::KIND_BEGIN) begin
            cmd.emit_last = 1'b1;
            state_d = S_IDLE;
          end else if (sts_i.room_le_len && sts_i.second_nz) begin
            state_d = S_COPY2;
          end else begin
            cmd.emit_last  = 1'b1;
            cmd.commit_row = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_COPY2: begin
        if (sts_i.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_sel   = bff_pkg::EM_COPY_SECOND;
          cmd.emit_last  = 1'b1;
          cmd.commit_row = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_END: begin
        if (sts_i.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = (sts_i.kind == bff_pkg::KIND_ROW) ? bff_pkg::EM_DONE
                                                            : bff_pkg::EM_EMPTY;
          cmd.emit_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // hold state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts_i.out_free)
    else $error("result loaded into an occupied output register");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the division state");

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

  a_split_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY2) |-> (sts_i.kind == bff_pkg::KIND_ROW))
    else $error("second copy part outside a row step");
`endif

endmodule

FILE: design/banked_framebuffer_flush.sv
// ----------------------------------------------------------------------------
// banked_framebuffer_flush: copy command generator for a banked aperture
// Turns rectangle and row-step items into page select and copy commands for
// flushing an 8-bit soft framebuffer through a paged display aperture.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries items: kind 0 starts a rectangle (x/y min inclusive, max
//   exclusive), kind 1 asks for the next row. out_o carries commands; the
//   last result of each item has last set. Configuration is written through
//   cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle.
//   A rectangle start goes through the clip/multiply step and the bit-serial
//   page divider, then the page select. An empty rectangle answers without
//   the divider. A row step takes an evaluation step and then gives one to
//   three results; the output register limits it to one result per cycle
//   while the receiver takes them.
//   One item is worked on at a time; the next is taken once the last result
//   of the current item sits in the output register.
//   Reset clears the flush state and restores the register defaults
//   (640 x 480, 64 KiB aperture, flushing off).
//   When the receiver stalls, the output register holds its result and the
//   controller waits before loading the next one.
// ----------------------------------------------------------------------------
module banked_framebuffer_flush #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bff_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bff_pkg::CFG_W-1:0]     cfg_data_i,
  bff_in_if.sink                        in_i,
  bff_out_if.source                     out_o
);

  bff_pkg::cmd_t cmd;
  bff_pkg::sts_t sts;

  bff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bff_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_kind_i   (in_i.kind),
    .in_x_min_i  (in_i.x_min),
    .in_y_min_i  (in_i.y_min),
    .in_x_max_i  (in_i.x_max),
    .in_y_max_i  (in_i.y_max),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_op_o    (out_o.op),
    .out_page_o  (out_o.page),
    .out_dest_o  (out_o.dest_offset),
    .out_src_o   (out_o.src_offset),
    .out_len_o   (out_o.length),
    .out_last_o  (out_o.last)
  );

endmodule

FILE: tb/banked_framebuffer_flush_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_framebuffer_flush_tb: self-checking bench for the flush generator
// Drives rectangle and row-step items under random source gaps and sink
// stalls. A behavioural copy of the page/offset arithmetic predicts the
// unpinned commands, and each output item is compared field by field in order.
// ----------------------------------------------------------------------------
module banked_framebuffer_flush_tb;

  localparam int unsigned MAX_W         = 2048;
  localparam int unsigned MAX_H         = 2048;
  localparam int unsigned RANDOM_ITEMS  = 64;
  localparam int unsigned QUIET_TAIL    = 16;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned AP_LOW        = 16;
  localparam int unsigned AP_HIGH       = 4194304;

  typedef struct packed {
    bff_pkg::op_e               op;
    logic [bff_pkg::PAGE_W-1:0] page;
    logic [bff_pkg::POS_W-1:0]  dest;
    logic [bff_pkg::POS_W-1:0]  src;
    logic [bff_pkg::DIM_W-1:0]  len;
    logic                       last;
  } flush_cmd_t;

  typedef struct {
    bit                               is_cfg;
    bff_pkg::cfg_idx_e                idx;
    int unsigned                      data;
    logic                             kind;
    logic signed [bff_pkg::CRD_W-1:0] xa, ya, xb, yb;
    bit                               pinned;
    bff_pkg::op_e                     pin_op;
  } stim_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [bff_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [bff_pkg::CFG_W-1:0]     cfg_data_i;

  bff_in_if  in_if ();
  bff_out_if out_if ();

  banked_framebuffer_flush #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // register copies and flush state of the predictor
  logic [bff_pkg::DIM_W-1:0]  fb_width   = bff_pkg::RST_WIDTH;
  logic [bff_pkg::DIM_W-1:0]  fb_height  = bff_pkg::RST_HEIGHT;
  logic [bff_pkg::AP_W-1:0]   ap_size    = bff_pkg::RST_AP;
  logic                       flush_on   = 1'b0;
  logic [bff_pkg::PAGE_W-1:0] cur_page   = '0;
  logic [bff_pkg::POS_W-1:0]  dest_pos   = '0;
  logic [bff_pkg::POS_W-1:0]  src_pos    = '0;
  logic [bff_pkg::DIM_W-1:0]  row_len    = '0;
  logic [bff_pkg::DIM_W-1:0]  rows_left  = '0;

  flush_cmd_t  step_cmds[$];
  flush_cmd_t  pending_cmds[$];
  stim_row_t   directed[$];
  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  bit          quiet       = 1'b0;
  bit          src_gaps    = 1'b0;
  bit          snk_stalls  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_width();
    return (fb_width > MAX_W) ? MAX_W : int'(fb_width);
  endfunction

  function automatic int unsigned eff_height();
    return (fb_height > MAX_H) ? MAX_H : int'(fb_height);
  endfunction

  function automatic int unsigned eff_aperture();
    if (ap_size < AP_LOW) return AP_LOW;
    if (ap_size > AP_HIGH) return AP_HIGH;
    return ap_size;
  endfunction

  function automatic int unsigned stride_of();
    return (eff_width() + 3) & 32'hFFFF_FFFC;
  endfunction

  function automatic void add_cmd(bff_pkg::op_e op, int unsigned pg, int unsigned dst,
                                  int unsigned src, int unsigned len);
    flush_cmd_t c;
    c.op   = op;
    c.page = bff_pkg::PAGE_W'(pg);
    c.dest = bff_pkg::POS_W'(dst);
    c.src  = bff_pkg::POS_W'(src);
    c.len  = bff_pkg::DIM_W'(len);
    c.last = 1'b0;
    step_cmds.push_back(c);
  endfunction

  // Work out the commands of one item and advance the flush state
  function automatic void flush_model(logic kind, logic signed [bff_pkg::CRD_W-1:0] xa,
                                      logic signed [bff_pkg::CRD_W-1:0] ya,
                                      logic signed [bff_pkg::CRD_W-1:0] xb,
                                      logic signed [bff_pkg::CRD_W-1:0] yb);
    int          x0, y0, x1, y1, w, h;
    int unsigned ap, stride, off, dp, room, len;
    ap     = eff_aperture();
    stride = stride_of();
    w      = int'(eff_width());
    h      = int'(eff_height());
    step_cmds.delete();
    if (kind == bff_pkg::KIND_BEGIN) begin
      x0 = xa;
      y0 = ya;
      x1 = xb;
      y1 = yb;
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > w) x1 = w;
      if (y1 > h) y1 = h;
      if (!flush_on || x0 >= x1 || y0 >= y1) begin
        rows_left = '0;
        add_cmd(bff_pkg::OP_NOTHING, 0, 0, 0, 0);
      end else begin
        off       = y0 * stride + x0;
        cur_page  = bff_pkg::PAGE_W'(off / ap);
        dest_pos  = bff_pkg::POS_W'(off % ap);
        src_pos   = bff_pkg::POS_W'(off);
        row_len   = bff_pkg::DIM_W'(x1 - x0);
        rows_left = bff_pkg::DIM_W'(y1 - y0);
        add_cmd(bff_pkg::OP_PAGE_SELECT, cur_page, 0, 0, 0);
      end
    end else if (rows_left == 0) begin
      add_cmd(bff_pkg::OP_ROWS_DONE, 0, 0, 0, 0);
    end else begin
      len = row_len;
      dp  = dest_pos;
      if (dp + stride < ap) begin
        add_cmd(bff_pkg::OP_COPY, 0, dp, src_pos, len);
        dest_pos = bff_pkg::POS_W'(dp + stride);
      end else begin
        // the row or the one after it reaches the page end
        room     = (dp < ap) ? ap - dp : 0;
        cur_page = cur_page + 1'b1;
        if (room <= len) begin
          if (room > 0) add_cmd(bff_pkg::OP_COPY, 0, dp, src_pos, room);
          add_cmd(bff_pkg::OP_PAGE_SELECT, cur_page, 0, 0, 0);
          if (len > room) add_cmd(bff_pkg::OP_COPY, 0, 0, src_pos + room, len - room);
        end else begin
          add_cmd(bff_pkg::OP_COPY, 0, dp, src_pos, len);
          add_cmd(bff_pkg::OP_PAGE_SELECT, cur_page, 0, 0, 0);
        end
        dest_pos = bff_pkg::POS_W'(dp + stride - ap);
      end
      src_pos   = bff_pkg::POS_W'(src_pos + stride);
      rows_left = rows_left - 1'b1;
    end
    step_cmds[step_cmds.size() - 1].last = 1'b1;
  endfunction

  function automatic void dir_item(logic kind, int xa, int ya, int xb, int yb,
                                   bit pinned = 1'b0,
                                   bff_pkg::op_e pin_op = bff_pkg::OP_NOTHING);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = bff_pkg::CFG_SCREEN_WIDTH;
    r.data   = 0;
    r.kind   = kind;
    r.xa     = bff_pkg::CRD_W'(xa);
    r.ya     = bff_pkg::CRD_W'(ya);
    r.xb     = bff_pkg::CRD_W'(xb);
    r.yb     = bff_pkg::CRD_W'(yb);
    r.pinned = pinned;
    r.pin_op = pin_op;
    directed.push_back(r);
  endfunction

  function automatic void dir_cfg(bff_pkg::cfg_idx_e idx, int unsigned value);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = value;
    r.kind   = bff_pkg::KIND_BEGIN;
    r.xa     = '0;
    r.ya     = '0;
    r.xb     = '0;
    r.yb     = '0;
    r.pinned = 1'b0;
    r.pin_op = bff_pkg::OP_NOTHING;
    directed.push_back(r);
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 5))
      0:       return 1;
      1:       return 4095;
      2:       return MAX_W;
      3:       return $urandom_range(1, 64);
      default: return $urandom_range(1, MAX_W);
    endcase
  endfunction

  function automatic int unsigned pick_height();
    case ($urandom_range(0, 4))
      0:       return 1;
      1:       return 4095;
      2:       return $urandom_range(1, 8);
      default: return $urandom_range(1, MAX_H);
    endcase
  endfunction

  // Often one to five strides, so that short rectangles still cross pages
  function automatic int unsigned pick_aperture();
    int unsigned stride;
    stride = stride_of();
    case ($urandom_range(0, 8))
      0:       return $urandom_range(0, AP_LOW - 1);
      1:       return AP_LOW;
      2:       return 65536;
      3:       return 8388607;
      4:       return $urandom_range(AP_LOW, 8388607);
      default: return stride * $urandom_range(1, 4) + $urandom_range(0, stride);
    endcase
  endfunction

  // Rectangle mostly starting on the screen and one to four rows tall
  task automatic gen_rect(output logic signed [bff_pkg::CRD_W-1:0] xa,
                          output logic signed [bff_pkg::CRD_W-1:0] ya,
                          output logic signed [bff_pkg::CRD_W-1:0] xb,
                          output logic signed [bff_pkg::CRD_W-1:0] yb);
    int x0, y0, x1, y1;
    if ($urandom_range(0, 7) == 0) begin
      xa = bff_pkg::CRD_W'($urandom);
      ya = bff_pkg::CRD_W'($urandom);
      xb = bff_pkg::CRD_W'($urandom);
      yb = bff_pkg::CRD_W'($urandom);
    end else begin
      x0 = $urandom_range(0, eff_width() - 1);
      x1 = x0 + $urandom_range(1, eff_width());
      y0 = $urandom_range(0, eff_height() - 1);
      y1 = y0 + $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) x0 = -int'($urandom_range(1, 4096));
      if ($urandom_range(0, 5) == 0) y0 = -int'($urandom_range(1, 4096));
      xa = bff_pkg::CRD_W'(x0);
      ya = bff_pkg::CRD_W'(y0);
      xb = bff_pkg::CRD_W'(x1);
      yb = bff_pkg::CRD_W'(y1);
    end
  endtask

  task automatic write_reg(bff_pkg::cfg_idx_e idx, int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= bff_pkg::CFG_W'(value);
    @(posedge clk_i);
    case (idx)
      bff_pkg::CFG_SCREEN_WIDTH:  fb_width  = bff_pkg::DIM_W'(value);
      bff_pkg::CFG_SCREEN_HEIGHT: fb_height = bff_pkg::DIM_W'(value);
      bff_pkg::CFG_APERTURE_SIZE: ap_size   = bff_pkg::AP_W'(value);
      bff_pkg::CFG_FLUSH_ENABLE:  flush_on  = value[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the source off until every predicted command has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_item(logic kind, logic signed [bff_pkg::CRD_W-1:0] xa,
                           logic signed [bff_pkg::CRD_W-1:0] ya,
                           logic signed [bff_pkg::CRD_W-1:0] xb,
                           logic signed [bff_pkg::CRD_W-1:0] yb,
                           bit pinned, bff_pkg::op_e pin_op);
    int unsigned gap;
    flush_cmd_t  pin_cmd;
    gap = 0;
    if (!quiet && src_gaps && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.x_min <= xa;
    in_if.y_min <= ya;
    in_if.x_max <= xb;
    in_if.y_max <= yb;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    flush_model(kind, xa, ya, xb, yb);
    if (pinned) begin
      pin_cmd      = '0;
      pin_cmd.op   = pin_op;
      pin_cmd.last = 1'b1;
      pending_cmds.push_back(pin_cmd);
    end else begin
      foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
    end
    items_sent++;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic check_result();
    flush_cmd_t want;
    if (pending_cmds.size() == 0) begin
      errors++;
      $display("%0t: command op %0d with none expected", $time, out_if.op);
    end else begin
      want = pending_cmds.pop_front();
      check_field("op", want.op, out_if.op);
      check_field("page", want.page, out_if.page);
      check_field("dest_offset", want.dest, out_if.dest_offset);
      check_field("src_offset", want.src, out_if.src_offset);
      check_field("length", want.len, out_if.length);
      check_field("last", want.last, out_if.last);
    end
  endtask

  // Check each output item, then stall the sink in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet && snk_stalls && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stop a hung run: count cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("banked_framebuffer_flush: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t                        r;
    int unsigned                      base, n_seq, n_rows;
    logic signed [bff_pkg::CRD_W-1:0] xa, ya, xb, yb;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= '0;
    cfg_data_i   <= '0;
    in_if.valid  <= 1'b0;
    in_if.kind   <= bff_pkg::KIND_BEGIN;
    in_if.x_min  <= '0;
    in_if.y_min  <= '0;
    in_if.x_max  <= '0;
    in_if.y_max  <= '0;

    // flushing is off after reset
    dir_item(bff_pkg::KIND_BEGIN, 0, 0, 10, 10, 1'b1, bff_pkg::OP_NOTHING);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0, 1'b1, bff_pkg::OP_ROWS_DONE);
    dir_cfg(bff_pkg::CFG_FLUSH_ENABLE, 1);
    // coordinate extremes clip to the whole screen
    dir_item(bff_pkg::KIND_BEGIN, -4096, -4096, 4095, 4095);
    // row straddles the page end: split copy around a page select
    dir_item(bff_pkg::KIND_BEGIN, 0, 102, 640, 104);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0);
    // row fits, the next would not: copy then page select
    dir_item(bff_pkg::KIND_BEGIN, 300, 101, 640, 103);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0);
    // empty clips, then a row step with the rows cleared
    dir_item(bff_pkg::KIND_BEGIN, 10, 10, 10, 20, 1'b1, bff_pkg::OP_NOTHING);
    dir_item(bff_pkg::KIND_BEGIN, -4096, -4096, -1, -1, 1'b1, bff_pkg::OP_NOTHING);
    dir_item(bff_pkg::KIND_BEGIN, 700, 0, 800, 10, 1'b1, bff_pkg::OP_NOTHING);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0, 1'b1, bff_pkg::OP_ROWS_DONE);
    // a new rectangle drops the one in progress
    dir_item(bff_pkg::KIND_BEGIN, 5, 5, 50, 50);
    dir_item(bff_pkg::KIND_BEGIN, 6, 7, 8, 9);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0);
    // saturated screen, aperture below its floor: page passes per row
    dir_cfg(bff_pkg::CFG_SCREEN_WIDTH, 4095);
    dir_cfg(bff_pkg::CFG_SCREEN_HEIGHT, 4095);
    dir_cfg(bff_pkg::CFG_APERTURE_SIZE, 0);
    dir_item(bff_pkg::KIND_BEGIN, 0, 0, 4095, 3);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0);
    dir_item(bff_pkg::KIND_BEGIN, 2040, 2047, 4095, 4095);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0);
    // aperture above its ceiling: the bottom row ends on the page end
    dir_cfg(bff_pkg::CFG_APERTURE_SIZE, 8388607);
    dir_item(bff_pkg::KIND_BEGIN, 0, 2047, 2048, 2048);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0);
    // one-pixel screen
    dir_cfg(bff_pkg::CFG_SCREEN_WIDTH, 1);
    dir_cfg(bff_pkg::CFG_SCREEN_HEIGHT, 1);
    dir_item(bff_pkg::KIND_BEGIN, 0, 0, 1, 1);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0);
    dir_item(bff_pkg::KIND_ROW, 0, 0, 0, 0, 1'b1, bff_pkg::OP_ROWS_DONE);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table
    src_gaps   = 1'b1;
    snk_stalls = 1'b1;
    foreach (directed[i]) begin
      r = directed[i];
      if (r.is_cfg) begin
        drain();
        write_reg(r.idx, r.data);
      end else begin
        send_item(r.kind, r.xa, r.ya, r.xb, r.yb, r.pinned, r.pin_op);
      end
    end

    // random phases: new settings, then rectangles walked row by row
    base = items_sent;
    while (items_sent < base + RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 1) != 0) write_reg(bff_pkg::CFG_SCREEN_WIDTH, pick_width());
      if ($urandom_range(0, 1) != 0) write_reg(bff_pkg::CFG_SCREEN_HEIGHT, pick_height());
      if ($urandom_range(0, 2) != 0) write_reg(bff_pkg::CFG_APERTURE_SIZE, pick_aperture());
      write_reg(bff_pkg::CFG_FLUSH_ENABLE, ($urandom_range(0, 7) != 0) ? 1 : 0);
      quiet      = (items_sent >= base + RANDOM_ITEMS - QUIET_TAIL);
      src_gaps   = ($urandom_range(0, 2) != 0);
      snk_stalls = ($urandom_range(0, 2) != 0);
      n_seq      = $urandom_range(2, 4);
      repeat (n_seq) begin
        gen_rect(xa, ya, xb, yb);
        send_item(bff_pkg::KIND_BEGIN, xa, ya, xb, yb, 1'b0, bff_pkg::OP_NOTHING);
        // cut tall rectangles short; sometimes step once past the end
        n_rows = rows_left;
        if (n_rows > 6) n_rows = $urandom_range(1, 6);
        else if ($urandom_range(0, 3) == 0) n_rows++;
        repeat (n_rows) begin
          if ($urandom_range(0, 11) == 0) begin
            drain();
            if ($urandom_range(0, 1) != 0) begin
              write_reg(bff_pkg::CFG_SCREEN_WIDTH, pick_width());
            end else begin
              write_reg(bff_pkg::CFG_APERTURE_SIZE, pick_aperture());
            end
          end
          send_item(bff_pkg::KIND_ROW, bff_pkg::CRD_W'($urandom),
                    bff_pkg::CRD_W'($urandom), bff_pkg::CRD_W'($urandom),
                    bff_pkg::CRD_W'($urandom), 1'b0, bff_pkg::OP_NOTHING);
        end
      end
    end

    drain();
    if (errors == 0 && pending_cmds.size() == 0) begin
      $display("banked_framebuffer_flush: match");
    end else begin
      $display("banked_framebuffer_flush: mismatch");
    end
    $finish;
  end

endmodule

FILE: banked_framebuffer_flush.f
design/bff_pkg.sv
design/bff_if.sv
design/bff_div.sv
design/bff_dp.sv
design/bff_ctrl.sv
design/banked_framebuffer_flush.sv
tb/banked_framebuffer_flush_tb.sv
